[hdl/rusi_pkg.sv]
`default_nettype none

package rusi_pkg;

    // Epsilon for the root test: EPS_SCALED / 2^EPS_SHIFT, about 1e-6.
    localparam int EPS_SHIFT = 40;
    localparam int EPS_W     = 21;
    localparam logic [EPS_W-1:0] EPS_SCALED = 21'd1099512;

endpackage

`default_nettype wire

[hdl/rusi_div.sv]
`default_nettype none

// Three restoring dividers sharing one divisor, one quotient bit per stage.
module rusi_div #(
    parameter int NUM_W = 65,
    parameter int DEN_W = 42,
    parameter int SB_W  = 67
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2:0][NUM_W-1:0]       num,
    input  logic [DEN_W-1:0]            den,
    input  logic [SB_W-1:0]             sb,
    output logic                        out_valid,
    output logic [2:0][NUM_W-1:0]       quo,
    output logic [2:0][DEN_W-1:0]       rem,
    output logic [DEN_W-1:0]            den_out,
    output logic [SB_W-1:0]             sb_out
);

    // pq holds the unused numerator bits on top and the quotient bits below
    logic [2:0][NUM_W-1:0] pq_reg  [NUM_W];
    logic [2:0][DEN_W-1:0] rem_reg [NUM_W];
    logic [DEN_W-1:0]      den_reg [NUM_W];
    logic [SB_W-1:0]       sb_reg  [NUM_W];
    logic [NUM_W-1:0]      vld_reg;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [2:0][NUM_W-1:0] pq_prev;
        logic [2:0][DEN_W-1:0] rem_prev;
        logic [DEN_W-1:0]      den_prev;
        logic [SB_W-1:0]       sb_prev;
        logic [2:0][NUM_W-1:0] pq_next;
        logic [2:0][DEN_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign pq_prev  = num;
            assign rem_prev = '0;
            assign den_prev = den;
            assign sb_prev  = sb;
        end
        else begin : g_rest
            assign pq_prev  = pq_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign sb_prev  = sb_reg[k-1];
        end

        always_comb
        begin
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           ge;
            for (int j = 0; j < 3; j++)
            begin
                trial = {rem_prev[j], pq_prev[j][NUM_W-1]};
                diff  = trial - {1'b0, den_prev};
                ge    = trial >= {1'b0, den_prev};
                rem_next[j] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                pq_next[j]  = {pq_prev[j][NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pq_reg[k]  <= pq_next;
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_prev;
                sb_reg[k]  <= sb_prev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_W-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quo       = pq_reg[NUM_W-1];
    assign rem       = rem_reg[NUM_W-1];
    assign den_out   = den_reg[NUM_W-1];
    assign sb_out    = sb_reg[NUM_W-1];

endmodule

`default_nettype wire

[hdl/ray_unit_sphere_intersect.sv]
`default_nettype none

// Channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------
// in       | in_valid / in_ready    | origin_x/y/z, dir_x/y/z (signed fixed)
// out      | out_valid / out_ready  | hit, hit_x/y/z (signed fixed, saturated)
//
// One transaction per cycle while the output is not stalled.
// SW = max(2*COORD_WIDTH, 2*FRAC_BITS+1) (42 at the defaults) sizes a, h and c.
// The pipeline holds the square root (one root bit per stage) and the
// divider (one quotient bit per stage) pipelines.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on the output freezes the whole pipeline; in_ready is low only then.
module ray_unit_sphere_intersect #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] hit_x,
    output logic signed [COORD_WIDTH-1:0] hit_y,
    output logic signed [COORD_WIDTH-1:0] hit_z
);

    import rusi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int SW  = (2*W > 2*FRAC_BITS+1) ? 2*W : 2*FRAC_BITS+1; // a, h, c magnitudes
    localparam int HL  = SW/2;
    localparam int HH  = SW-HL;
    localparam int PPW = 2*SW;          // h^2 and a*c
    localparam int DWE = 2*SW+2;        // discriminant, even width for the root
    localparam int RW  = SW+1;          // root
    localparam int NW  = SW+3;          // signed root numerator
    localparam int MW  = SW+2;          // numerator magnitude
    localparam int ML  = MW/2;
    localparam int MH  = MW-ML;
    localparam int PW  = MW+W;          // N * |d|
    localparam int EW  = MW+EPS_SHIFT;  // epsilon compare
    localparam int VW  = PW+2;          // origin + offset

    typedef struct packed {
        logic [2:0][W-1:0] o;   // origin, raw two's complement
        logic [2:0]        dn;  // direction signs
        logic [2:0][W-1:0] dm;  // direction magnitudes
    } ray_t;

    typedef struct packed {
        ray_t          ray;
        logic [SW-1:0] a;
        logic [SW-1:0] hm;
        logic          hn;
        logic          miss;
    } sqsb_t;

    typedef struct packed {
        logic [2:0][W-1:0] o;
        logic [2:0]        dn;
        logic              hit;
    } dsb_t;

    localparam int SB_W = $bits(dsb_t);

    logic en;

    // whole pipeline advances unless the output holds a result not taken
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: magnitudes and signs
    logic              v1_reg;
    ray_t              ray1_reg;
    logic [2:0][W-1:0] om1_reg;

    // ---------------- stage 2: component products
    logic                v2_reg;
    ray_t                ray2_reg;
    logic [2:0][2*W-1:0] pa2_reg, po2_reg, ph2_reg;
    logic [2:0]          hx2_reg;

    // ---------------- stage 3: dot products
    logic          v3_reg;
    ray_t          ray3_reg;
    logic [SW-1:0] a3_reg, oo3_reg, hp3_reg, hq3_reg;

    // ---------------- stage 4: h and c as sign and magnitude
    logic          v4_reg;
    ray_t          ray4_reg;
    logic [SW-1:0] a4_reg, hm4_reg, cm4_reg;
    logic          hn4_reg, cn4_reg, miss4_reg;

    // ---------------- stage 5: partial products of h^2 and a*c
    logic              v5_reg;
    ray_t              ray5_reg;
    logic [SW-1:0]     a5_reg, hm5_reg;
    logic              hn5_reg, cn5_reg, miss5_reg;
    logic [2*HL-1:0]   hll5_reg;
    logic [HL+HH-1:0]  hlh5_reg;
    logic [2*HH-1:0]   hhh5_reg;
    logic [2*HL-1:0]   all5_reg;
    logic [HL+HH-1:0]  alh5_reg, ahl5_reg;
    logic [2*HH-1:0]   ahh5_reg;

    // ---------------- stage 6: h^2 and a*c
    logic           v6_reg;
    ray_t           ray6_reg;
    logic [SW-1:0]  a6_reg, hm6_reg;
    logic           hn6_reg, cn6_reg, miss6_reg;
    logic [PPW-1:0] h2_6_reg, ac6_reg;

    // ---------------- stage 7: discriminant
    logic           v7_reg;
    sqsb_t          sb7_reg;
    logic [DWE-1:0] disc7_reg;

    // ---------------- square root, one bit per stage
    logic [DWE-1:0]  sq_val_reg  [RW];
    logic [RW+1:0]   sq_rem_reg  [RW];
    logic [RW-1:0]   sq_root_reg [RW];
    sqsb_t           sq_sb_reg   [RW];
    logic [RW-1:0]   sq_vld_reg;

    // ---------------- stage 8: root numerators, a*eps partials
    logic                 v8_reg;
    ray_t                 ray8_reg;
    logic [SW-1:0]        a8_reg;
    logic                 miss8_reg;
    logic [NW-1:0]        n1_8_reg, n2_8_reg;
    logic [HL+EPS_W-1:0]  ael8_reg;
    logic [HH+EPS_W-1:0]  aeh8_reg;

    // ---------------- stage 9: a*eps
    logic          v9_reg;
    ray_t          ray9_reg;
    logic [SW-1:0] a9_reg;
    logic          miss9_reg;
    logic [NW-1:0] n1_9_reg, n2_9_reg;
    logic [EW-1:0] aeps9_reg;

    // ---------------- stage 10: root choice
    logic          v10_reg;
    ray_t          ray10_reg;
    logic [SW-1:0] a10_reg;
    logic          hit10_reg;
    logic [MW-1:0] nm10_reg;

    // ---------------- stage 11: partial products N*|d|
    logic               v11_reg;
    ray_t               ray11_reg;
    logic [SW-1:0]      a11_reg;
    logic               hit11_reg;
    logic [2:0][ML+W-1:0] pl11_reg;
    logic [2:0][MH+W-1:0] ph11_reg;

    // ---------------- stage 12: N*|d|
    logic             v12_reg;
    dsb_t             dsb12_reg;
    logic [SW-1:0]    a12_reg;
    logic [2:0][PW-1:0] p12_reg;

    // ---------------- divider outputs
    logic               dv_valid;
    logic [2:0][PW-1:0] dv_quo;
    logic [2:0][SW-1:0] dv_rem;
    logic [SW-1:0]      dv_den;
    logic [SB_W-1:0]    dv_sb;
    dsb_t               dv_sbt;

    // ---------------- stage 13: rounded offsets
    logic               v13_reg;
    dsb_t               dsb13_reg;
    logic [2:0][PW:0]   q13_reg;

    // ---------------- output register
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic signed [W-1:0]  hit_x_reg, hit_y_reg, hit_z_reg;

    // ---------------------------------------------------------------
    // combinational pieces
    // ---------------------------------------------------------------
    logic [2:0][W-1:0] in_o, in_d;
    ray_t              ray_in;
    logic [2:0][W-1:0] om_in;

    assign in_o = {origin_z, origin_y, origin_x};
    assign in_d = {dir_z, dir_y, dir_x};

    always_comb
    begin
        ray_in.o = in_o;
        for (int i = 0; i < 3; i++)
        begin
            ray_in.dn[i] = in_d[i][W-1];
            ray_in.dm[i] = in_d[i][W-1] ? (~in_d[i] + W'(1)) : in_d[i];
            om_in[i]     = in_o[i][W-1] ? (~in_o[i] + W'(1)) : in_o[i];
        end
    end

    logic [SW-1:0] a_sum, oo_sum, hp_sum, hq_sum;

    always_comb
    begin
        a_sum  = '0;
        oo_sum = '0;
        hp_sum = '0;
        hq_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            a_sum  = a_sum + SW'(pa2_reg[i]);
            oo_sum = oo_sum + SW'(po2_reg[i]);
            if (hx2_reg[i])
            begin
                hq_sum = hq_sum + SW'(ph2_reg[i]);
            end
            else
            begin
                hp_sum = hp_sum + SW'(ph2_reg[i]);
            end
        end
    end

    logic [SW-1:0] s_one;   // 1.0 at scale S^2
    assign s_one = SW'(1) << (2*FRAC_BITS);

    logic [PPW-1:0] h2_sum, ac_sum;
    assign h2_sum = PPW'(hll5_reg) + (PPW'(hlh5_reg) << (HL+1)) + (PPW'(hhh5_reg) << (2*HL));
    assign ac_sum = PPW'(all5_reg) + (PPW'(alh5_reg) << HL) + (PPW'(ahl5_reg) << HL)
                  + (PPW'(ahh5_reg) << (2*HL));

    sqsb_t sb_into_sqrt;
    always_comb
    begin
        sb_into_sqrt.ray  = ray6_reg;
        sb_into_sqrt.a    = a6_reg;
        sb_into_sqrt.hm   = hm6_reg;
        sb_into_sqrt.hn   = hn6_reg;
        sb_into_sqrt.miss = miss6_reg || (!cn6_reg && (h2_6_reg < ac6_reg));
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [DWE-1:0] val_prev;
        logic [RW+1:0]  rem_prev;
        logic [RW-1:0]  root_prev;
        sqsb_t          sb_prev;
        logic [RW+3:0]  rin, trial, diff;
        logic           ge;

        if (k == 0) begin : g_first
            assign val_prev  = disc7_reg;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign sb_prev   = sb7_reg;
        end
        else begin : g_rest
            assign val_prev  = sq_val_reg[k-1];
            assign rem_prev  = sq_rem_reg[k-1];
            assign root_prev = sq_root_reg[k-1];
            assign sb_prev   = sq_sb_reg[k-1];
        end

        assign rin   = {rem_prev, val_prev[DWE-1 -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign diff  = rin - trial;
        assign ge    = rin >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_val_reg[k]  <= val_prev << 2;
                sq_rem_reg[k]  <= ge ? diff[RW+1:0] : rin[RW+1:0];
                sq_root_reg[k] <= {root_prev[RW-2:0], ge};
                sq_sb_reg[k]   <= sb_prev;
            end
        end
    end

    sqsb_t         sbq;
    logic [NW-1:0] mh_q, root_q;
    assign sbq    = sq_sb_reg[RW-1];
    assign root_q = NW'(sq_root_reg[RW-1]);
    // -h as a two's complement value
    assign mh_q   = sbq.hn ? NW'(sbq.hm) : (NW'(0) - NW'(sbq.hm));

    logic b1, b2;
    assign b1 = !n1_9_reg[NW-1] && (n1_9_reg != '0)
             && ((EW'(n1_9_reg[MW-1:0]) << EPS_SHIFT) > aeps9_reg);
    assign b2 = !n2_9_reg[NW-1] && (n2_9_reg != '0)
             && ((EW'(n2_9_reg[MW-1:0]) << EPS_SHIFT) > aeps9_reg);

    dsb_t dsb_in;
    assign dsb_in.o   = ray11_reg.o;
    assign dsb_in.dn  = ray11_reg.dn;
    assign dsb_in.hit = hit11_reg;

    rusi_div #(
        .NUM_W (PW),
        .DEN_W (SW),
        .SB_W  (SB_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v12_reg),
        .num       (p12_reg),
        .den       (a12_reg),
        .sb        (dsb12_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .rem       (dv_rem),
        .den_out   (dv_den),
        .sb_out    (dv_sb)
    );

    assign dv_sbt = dsb_t'(dv_sb);

    logic signed [VW-1:0] vmax_c, vmin_c;
    assign vmax_c = $signed({{(VW-W+1){1'b0}}, {(W-1){1'b1}}});
    assign vmin_c = $signed({{(VW-W+1){1'b1}}, {(W-1){1'b0}}});

    logic [2:0][W-1:0] coord_next;
    always_comb
    begin
        logic signed [VW-1:0] base;
        logic signed [VW-1:0] off;
        logic signed [VW-1:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            base = VW'($signed(dsb13_reg.o[i]));
            off  = $signed(VW'(q13_reg[i]));
            sum  = dsb13_reg.dn[i] ? (base - off) : (base + off);
            if (!dsb13_reg.hit)
            begin
                coord_next[i] = '0;
            end
            else if (sum > vmax_c)
            begin
                coord_next[i] = vmax_c[W-1:0];
            end
            else if (sum < vmin_c)
            begin
                coord_next[i] = vmin_c[W-1:0];
            end
            else
            begin
                coord_next[i] = sum[W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // valid chain
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            sq_vld_reg    <= '0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            v13_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            sq_vld_reg    <= {sq_vld_reg[RW-2:0], v7_reg};
            v8_reg        <= sq_vld_reg[RW-1];
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            v12_reg       <= v11_reg;
            v13_reg       <= dv_valid;
            out_valid_reg <= v13_reg;
        end
    end

    // ---------------------------------------------------------------
    // payload
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            ray1_reg <= ray_in;
            om1_reg  <= om_in;

            // stage 2
            ray2_reg <= ray1_reg;
            for (int i = 0; i < 3; i++)
            begin
                pa2_reg[i] <= ray1_reg.dm[i] * ray1_reg.dm[i];
                po2_reg[i] <= om1_reg[i] * om1_reg[i];
                ph2_reg[i] <= om1_reg[i] * ray1_reg.dm[i];
                hx2_reg[i] <= ray1_reg.o[i][W-1] ^ ray1_reg.dn[i];
            end

            // stage 3
            ray3_reg <= ray2_reg;
            a3_reg   <= a_sum;
            oo3_reg  <= oo_sum;
            hp3_reg  <= hp_sum;
            hq3_reg  <= hq_sum;

            // stage 4
            ray4_reg  <= ray3_reg;
            a4_reg    <= a3_reg;
            hn4_reg   <= hq3_reg > hp3_reg;
            hm4_reg   <= (hq3_reg > hp3_reg) ? (hq3_reg - hp3_reg) : (hp3_reg - hq3_reg);
            cn4_reg   <= oo3_reg < s_one;
            cm4_reg   <= (oo3_reg < s_one) ? (s_one - oo3_reg) : (oo3_reg - s_one);
            miss4_reg <= a3_reg == '0;

            // stage 5
            ray5_reg  <= ray4_reg;
            a5_reg    <= a4_reg;
            hm5_reg   <= hm4_reg;
            hn5_reg   <= hn4_reg;
            cn5_reg   <= cn4_reg;
            miss5_reg <= miss4_reg;
            hll5_reg  <= hm4_reg[HL-1:0] * hm4_reg[HL-1:0];
            hlh5_reg  <= hm4_reg[HL-1:0] * hm4_reg[SW-1:HL];
            hhh5_reg  <= hm4_reg[SW-1:HL] * hm4_reg[SW-1:HL];
            all5_reg  <= a4_reg[HL-1:0] * cm4_reg[HL-1:0];
            alh5_reg  <= a4_reg[HL-1:0] * cm4_reg[SW-1:HL];
            ahl5_reg  <= a4_reg[SW-1:HL] * cm4_reg[HL-1:0];
            ahh5_reg  <= a4_reg[SW-1:HL] * cm4_reg[SW-1:HL];

            // stage 6
            ray6_reg  <= ray5_reg;
            a6_reg    <= a5_reg;
            hm6_reg   <= hm5_reg;
            hn6_reg   <= hn5_reg;
            cn6_reg   <= cn5_reg;
            miss6_reg <= miss5_reg;
            h2_6_reg  <= h2_sum;
            ac6_reg   <= ac_sum;

            // stage 7: c < 0 adds, otherwise subtracts
            sb7_reg   <= sb_into_sqrt;
            disc7_reg <= cn6_reg ? (DWE'(h2_6_reg) + DWE'(ac6_reg))
                                 : (DWE'(h2_6_reg) - DWE'(ac6_reg));

            // stage 8
            ray8_reg  <= sbq.ray;
            a8_reg    <= sbq.a;
            miss8_reg <= sbq.miss;
            n1_8_reg  <= mh_q - root_q;
            n2_8_reg  <= mh_q + root_q;
            ael8_reg  <= sbq.a[HL-1:0] * EPS_SCALED;
            aeh8_reg  <= sbq.a[SW-1:HL] * EPS_SCALED;

            // stage 9
            ray9_reg  <= ray8_reg;
            a9_reg    <= a8_reg;
            miss9_reg <= miss8_reg;
            n1_9_reg  <= n1_8_reg;
            n2_9_reg  <= n2_8_reg;
            aeps9_reg <= EW'(ael8_reg) + (EW'(aeh8_reg) << HL);

            // stage 10: nearer root first; a chosen root is always positive
            ray10_reg <= ray9_reg;
            a10_reg   <= a9_reg;
            hit10_reg <= !miss9_reg && (b1 || b2);
            nm10_reg  <= b1 ? n1_9_reg[MW-1:0] : n2_9_reg[MW-1:0];

            // stage 11
            ray11_reg <= ray10_reg;
            a11_reg   <= a10_reg;
            hit11_reg <= hit10_reg;
            for (int i = 0; i < 3; i++)
            begin
                pl11_reg[i] <= nm10_reg[ML-1:0] * ray10_reg.dm[i];
                ph11_reg[i] <= nm10_reg[MW-1:ML] * ray10_reg.dm[i];
            end

            // stage 12
            dsb12_reg <= dsb_in;
            a12_reg   <= a11_reg;
            for (int i = 0; i < 3; i++)
            begin
                p12_reg[i] <= PW'(pl11_reg[i]) + (PW'(ph11_reg[i]) << ML);
            end

            // stage 13: round half away from zero on the magnitude
            dsb13_reg <= dv_sbt;
            for (int i = 0; i < 3; i++)
            begin
                q13_reg[i] <= (PW+1)'(dv_quo[i])
                            + (PW+1)'({dv_rem[i], 1'b0} >= {1'b0, dv_den});
            end

            // output register
            hit_reg   <= dsb13_reg.hit;
            hit_x_reg <= $signed(coord_next[0]);
            hit_y_reg <= $signed(coord_next[1]);
            hit_z_reg <= $signed(coord_next[2]);
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;
    assign hit_z     = hit_z_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> hit_x_reg == '0 && hit_y_reg == '0 && hit_z_reg == '0)
        else $error("miss result with nonzero coordinates");

    a_root_pos: assert property (@(posedge clk) disable iff (!rst_n)
        v10_reg && hit10_reg |-> nm10_reg != '0)
        else $error("chosen root numerator is zero");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted transaction did not enter stage 1");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v1_reg) && $stable(v13_reg) && $stable(sq_vld_reg))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
